[src/gdil_pkg.sv]
// Shared constants, register codes and helpers for the grayscale dilation block.
`default_nettype none

package gdil_pkg;

    // Default sizing of the frame store and neighbourhood
    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_MAX_OFFSETS = 16;
    localparam int DEF_PIXEL_BITS  = 8;

    // Offset slots held by the two 64-bit table registers
    localparam int TABLE_SLOTS = 16;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_COUNT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TABLE_LOW    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TABLE_HIGH   = 3'd4;

    // Register reset values
    localparam logic [8:0] RST_IMAGE_WIDTH  = 9'd256;
    localparam logic [8:0] RST_IMAGE_HEIGHT = 9'd256;

    // Request kinds carried in tuser
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Sign-extend a 4-bit offset component to a 10-bit coordinate delta
    function automatic logic signed [9:0] sext_nib(input logic [3:0] nib);
        return {{6{nib[3]}}, nib};
    endfunction

endpackage

`default_nettype wire

[src/grayscale_dilation_top.sv]
// Grayscale dilation: frame store, offset sequencer and running-maximum unit.
// Flow: a write is stored at its accept edge, no result; a compute scans the centre pixel and
//   its n offsets (n = offsets in use, at most 16), drains the last read and shows its result,
//   skipping the scan outside the image. Throughput: one write per cycle while idle; no request
//   is taken until a compute's result goes out, and a waiting result holds the next one.
// Reset: synchronous, active low; clears sequencer, result valid, settings; keeps the store.
`default_nettype none

module grayscale_dilation_top
    import gdil_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int MAX_OFFSETS = DEF_MAX_OFFSETS,
    parameter int PIXEL_BITS  = DEF_PIXEL_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Input requests
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire logic [23:0]             i_s_axis_tdata,  // pos_x, pos_y, pixel_value
    input  wire logic                    i_s_axis_tuser,  // opcode
    // Results
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    output logic [7:0]                   o_m_axis_tdata,  // dilated_value
    // Configuration writes
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [63:0]             i_cfg_data
);

    localparam int Depth     = MAX_WIDTH * MAX_HEIGHT;
    localparam int AddrBits  = $clog2(Depth);
    localparam int WClip     = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
    localparam int HClip     = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam int NCap      = (MAX_OFFSETS < TABLE_SLOTS) ? MAX_OFFSETS : TABLE_SLOTS;

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // Configuration registers
    logic [8:0]   r_width;
    logic [8:0]   r_height;
    logic [4:0]   r_count;
    logic [127:0] r_table;

    // Sequencer and datapath registers
    logic [1:0]            r_state, n_state;
    logic [7:0]            r_x, n_x;
    logic [7:0]            r_y, n_y;
    logic [4:0]            r_step, n_step;
    logic [4:0]            r_last, n_last;
    logic [PIXEL_BITS-1:0] r_best, n_best;
    logic                  r_rd_live, n_rd_live;
    logic [PIXEL_BITS-1:0] r_rd_data;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_data, n_out_data;

    logic [PIXEL_BITS-1:0] r_frame [Depth];

    // Handshake and field decode
    logic        s_accept;
    logic [7:0]  in_x, in_y, in_pix;
    logic        in_op;
    logic [15:0] pix_ext;
    logic [15:0] best_ext;
    logic [8:0]  w_eff, h_eff;
    logic [4:0]  n_eff;

    // Neighbour address unit
    logic [3:0]         slot;
    logic [7:0]         slot_byte;
    logic signed [9:0]  dx, dy, nx, ny;
    logic               nb_in;
    logic [8:0]         col, row;
    logic [AddrBits-1:0] addr;
    logic               mem_we, rd_en;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op    = i_s_axis_tuser;
    assign in_x     = i_s_axis_tdata[7:0];
    assign in_y     = i_s_axis_tdata[15:8];
    assign in_pix   = i_s_axis_tdata[23:16];
    assign pix_ext  = 16'(in_pix);
    assign best_ext = 16'(r_best);

    // Clip image size and offset count to what the store and table hold
    assign w_eff = (r_width  > 9'(WClip)) ? 9'(WClip) : r_width;
    assign h_eff = (r_height > 9'(HClip)) ? 9'(HClip) : r_height;
    assign n_eff = (r_count  > 5'(NCap))  ? 5'(NCap)  : r_count;

    // Pick the offset for this step; step zero is the centre pixel
    assign slot      = 4'(r_step - 5'd1);
    assign slot_byte = r_table[{slot, 3'b000} +: 8];
    assign dx        = (r_step == 5'd0) ? 10'sd0 : sext_nib(slot_byte[3:0]);
    assign dy        = (r_step == 5'd0) ? 10'sd0 : sext_nib(slot_byte[7:4]);
    assign nx        = $signed({2'b00, r_x}) + dx;
    assign ny        = $signed({2'b00, r_y}) + dy;
    assign nb_in     = !nx[9] && !ny[9]
                       && (nx < $signed({1'b0, w_eff}))
                       && (ny < $signed({1'b0, h_eff}));

    // Shared address unit: request position when idle, neighbour when scanning
    always_comb begin
        if (r_state == S_SCAN) begin
            col = nx[8:0];
            row = ny[8:0];
        end else begin
            col = 9'(in_x);
            row = 9'(in_y);
        end
    end
    assign addr = AddrBits'(row) * AddrBits'(MAX_WIDTH) + AddrBits'(col);

    assign mem_we = s_accept && (in_op == OP_WRITE)
                    && (13'(in_x) < 13'(MAX_WIDTH)) && (13'(in_y) < 13'(MAX_HEIGHT));
    assign rd_en  = (r_state == S_SCAN) && nb_in;

    // Frame store: one port, written when idle, read while scanning
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame[addr] <= pix_ext[PIXEL_BITS-1:0];
        end
        if (rd_en) begin
            r_rd_data <= r_frame[addr];
        end
    end

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_count  <= 5'd0;
            r_table  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width          <= i_cfg_data[8:0];
                CFG_IMAGE_HEIGHT: r_height         <= i_cfg_data[8:0];
                CFG_OFFSET_COUNT: r_count          <= i_cfg_data[4:0];
                CFG_TABLE_LOW:    r_table[63:0]    <= i_cfg_data;
                CFG_TABLE_HIGH:   r_table[127:64]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: capture request, step through offsets, fold maximum, hand over result
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_step      = r_step;
        n_last      = r_last;
        n_best      = r_best;
        n_rd_live   = r_rd_live;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // Drop the result once taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // Fold the pixel read in the previous cycle
        if (r_rd_live && (r_rd_data > r_best)) begin
            n_best = r_rd_data;
        end

        unique case (r_state)
            S_IDLE: begin
                n_rd_live = 1'b0;
                if (s_accept && (in_op == OP_COMPUTE)) begin
                    n_x    = in_x;
                    n_y    = in_y;
                    n_step = 5'd0;
                    n_last = n_eff;
                    n_best = '0;
                    if ((9'(in_x) >= w_eff) || (9'(in_y) >= h_eff)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_rd_live = nb_in;
                n_step    = r_step + 5'd1;
                if (r_step == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_rd_live = 1'b0;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = best_ext[7:0];
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_live   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_live   <= n_rd_live;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_step     <= n_step;
        r_last     <= n_last;
        r_best     <= n_best;
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    // A write request never produces a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (in_op == OP_WRITE) && !r_out_valid) |=> !r_out_valid)
        else $error("write request produced a result");

    // A compute request holds off further requests
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (in_op == OP_COMPUTE)) |=> !o_s_axis_tready)
        else $error("accepted a request during a compute");

    // The single store port is never read and written together
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && rd_en))
        else $error("frame store read and write in the same cycle");

    // The step counter stays within the offsets in use
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_step <= r_last))
        else $error("offset step overran the count");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

[dv/dilation_checker.sv]
// Checker for the grayscale dilation block: tracks settings and pixels, predicts and compares.
`timescale 1ns / 100ps

module dilation_checker
    import gdil_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    input  wire logic                    i_s_tready,
    input  wire logic [23:0]             i_s_tdata,   // pos_x, pos_y, pixel_value
    input  wire logic                    i_s_tuser,   // opcode
    input  wire logic                    i_m_tvalid,
    input  wire logic                    i_m_tready,
    input  wire logic [7:0]              i_m_tdata,   // dilated_value
    input  wire logic                    i_cfg_valid,
    input  wire logic                    i_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [63:0]             i_cfg_data,
    output int                           o_mismatch_count,
    output int                           o_pending
);

    // Shadow copy of the configuration and of the frame store
    logic [8:0]  img_width;
    logic [8:0]  img_height;
    logic [4:0]  nbr_count;
    logic [63:0] nbr_tab_lo;
    logic [63:0] nbr_tab_hi;
    logic [7:0]  pixel_mem [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];

    // Dilated values still owed by the block, oldest first
    logic [7:0]  dilated_q [$];
    logic [7:0]  owed;
    int          mismatches = 0;

    // Maximum over the centre pixel and every in-bounds neighbour; zero outside the image
    function automatic logic [7:0] dilate_at(input logic [7:0] px, input logic [7:0] py);
        int         w;
        int         h;
        int         n;
        int         dx;
        int         dy;
        int         nx;
        int         ny;
        logic [7:0] code;
        logic [7:0] peak;
        w = (img_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(img_width);
        h = (img_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(img_height);
        if (int'(px) >= w || int'(py) >= h) begin
            return '0;
        end
        n = int'(nbr_count);
        if (n > TABLE_SLOTS) n = TABLE_SLOTS;
        if (n > DEF_MAX_OFFSETS) n = DEF_MAX_OFFSETS;
        peak = pixel_mem[int'(py) * DEF_MAX_WIDTH + int'(px)];
        for (int i = 0; i < n; i++) begin
            code = (i < 8) ? nbr_tab_lo[i*8 +: 8] : nbr_tab_hi[(i-8)*8 +: 8];
            dx = $signed(code[3:0]);
            dy = $signed(code[7:4]);
            nx = int'(px) + dx;
            ny = int'(py) + dy;
            if (nx >= 0 && ny >= 0 && nx < w && ny < h) begin
                if (pixel_mem[ny * DEF_MAX_WIDTH + nx] > peak)
                    peak = pixel_mem[ny * DEF_MAX_WIDTH + nx];
            end
        end
        return peak;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            img_width  = RST_IMAGE_WIDTH;
            img_height = RST_IMAGE_HEIGHT;
            nbr_count  = '0;
            nbr_tab_lo = '0;
            nbr_tab_hi = '0;
            dilated_q.delete();
            o_pending        <= 0;
            o_mismatch_count <= mismatches;
        end else begin
            // Track register writes; unused indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  img_width  = i_cfg_data[8:0];
                    CFG_IMAGE_HEIGHT: img_height = i_cfg_data[8:0];
                    CFG_OFFSET_COUNT: nbr_count  = i_cfg_data[4:0];
                    CFG_TABLE_LOW:    nbr_tab_lo = i_cfg_data;
                    CFG_TABLE_HIGH:   nbr_tab_hi = i_cfg_data;
                    default: ;
                endcase
            end

            // Retire results before taking new requests
            if (i_m_tvalid && i_m_tready) begin
                if (dilated_q.size() == 0) begin
                    $display("%0t: result %02h arrived with no compute request waiting",
                             $time, i_m_tdata);
                    mismatches++;
                end else begin
                    owed = dilated_q.pop_front();
                    if (i_m_tdata !== owed) begin
                        $display("%0t: dilated_value mismatch, expected %02h, got %02h",
                                 $time, owed, i_m_tdata);
                        mismatches++;
                    end
                end
            end

            // Store pixels, predict computes
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_WRITE)
                    pixel_mem[int'(i_s_tdata[15:8]) * DEF_MAX_WIDTH + int'(i_s_tdata[7:0])] =
                        i_s_tdata[23:16];
                else
                    dilated_q.push_back(dilate_at(i_s_tdata[7:0], i_s_tdata[15:8]));
            end

            o_pending        <= dilated_q.size();
            o_mismatch_count <= mismatches;
        end
    end

endmodule

[dv/tb_grayscale_dilation_top.sv]
// Testbench top for the grayscale dilation block: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps

module tb_grayscale_dilation_top;
    import gdil_pkg::*;

    localparam int RANDOM_ITEMS   = 290;
    localparam int DRAIN_PAD      = 24;    // beyond the longest compute, of 16 offsets
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_INDEX = '1;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    s_tvalid    = 1'b0;
    logic [23:0]             s_tdata     = '0;
    logic                    s_tuser     = OP_WRITE;
    logic                    m_tready    = 1'b0;
    logic                    cfg_valid   = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index   = CFG_IMAGE_WIDTH;
    logic [63:0]             cfg_data    = '0;
    logic                    s_tready;
    logic                    m_tvalid;
    logic [7:0]              m_tdata;
    logic                    cfg_ready;

    int mismatch_count;
    int pending_results;
    int burst_left   = 0;
    int eff_w        = DEF_MAX_WIDTH;
    int eff_h        = DEF_MAX_HEIGHT;
    int writes_sent  = 0;
    int computes_sent = 0;
    int settings_used = 0;
    int idle_cycles  = 0;
    int rx_mode_left = 0;
    bit rx_stalling  = 1'b0;

    always #1 i_clk = ~i_clk;

    grayscale_dilation_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    dilation_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_results)
    );

    // Result side: alternate free-running and randomly stalling stretches
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_stalling  <= ($urandom_range(0, 1) == 1);
            rx_mode_left <= $urandom_range(50, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        if (!rx_stalling)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) == 0);
    end

    // Watchdog: end the run if nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one request, in bursts with random gaps between them
    task automatic send_request(input logic op, input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pix, y, x};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
        if (op == OP_WRITE)
            writes_sent++;
        else
            computes_sent++;
    endtask

    // Hold the sender until every owed result is back, then let the block settle
    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    // Program all registers; only called with the block idle
    task automatic set_up_image(input int w, input int h, input int cnt,
                                input logic [63:0] lo, input logic [63:0] hi);
        cfg_write(CFG_IMAGE_WIDTH, 64'(w));
        cfg_write(CFG_IMAGE_HEIGHT, 64'(h));
        cfg_write(CFG_OFFSET_COUNT, 64'(cnt));
        cfg_write(CFG_TABLE_LOW, lo);
        cfg_write(CFG_TABLE_HIGH, hi);
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_IDX_BITS'($urandom_range(CFG_TABLE_HIGH + 1, CFG_LAST_INDEX)),
                      {$urandom, $urandom});
        cfg_valid <= 1'b0;
        eff_w = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
        eff_h = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
        settings_used++;
    endtask

    // Offsets of -1, 0 or +1 in each direction, so small images see many neighbours
    function automatic logic [63:0] near_offsets();
        logic [63:0] t;
        int          k;
        for (int i = 0; i < 16; i++) begin
            k = $urandom_range(0, 2);
            t[i*4 +: 4] = (k == 0) ? 4'hF : 4'(k - 1);
        end
        return t;
    endfunction

    // Fill the whole active band in raster order, with the odd stray write anywhere
    task automatic load_band();
        for (int y = 0; y < eff_h; y++) begin
            for (int x = 0; x < eff_w; x++) begin
                send_request(OP_WRITE, 8'(x), 8'(y), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0)
                    send_request(OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Fill one window of a large band in raster order
    task automatic load_window(input int x0, input int x1, input int y0, input int y1);
        for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++)
                send_request(OP_WRITE, 8'(x), 8'(y), 8'($urandom_range(0, 255)));
    endtask

    // Computes where every in-image neighbour lies in the loaded window, plus some outside the image
    task automatic run_window_computes(input int count, input int x0, input int x1,
                                       input int y0, input int y1);
        repeat (count) begin
            if ($urandom_range(0, 3) != 0)
                send_request(OP_COMPUTE, 8'($urandom_range(x0, x1)),
                             8'($urandom_range(y0, y1)), 8'($urandom));
            else if (eff_h < DEF_MAX_HEIGHT)
                send_request(OP_COMPUTE, 8'($urandom),
                             8'($urandom_range(eff_h, 255)), 8'($urandom));
            else
                send_request(OP_COMPUTE, 8'($urandom_range(eff_w, 255)),
                             8'($urandom), 8'($urandom));
        end
    endtask

    // Mostly computes inside the band, some anywhere, some rewrites and a rare full pause
    task automatic run_computes(input int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 19);
            if (r < 14 && eff_w > 0 && eff_h > 0)
                send_request(OP_COMPUTE, 8'($urandom_range(0, eff_w - 1)),
                             8'($urandom_range(0, eff_h - 1)), 8'($urandom));
            else if (r < 17)
                send_request(OP_COMPUTE, 8'($urandom), 8'($urandom), 8'($urandom));
            else if (r < 19)
                send_request(OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                drain_results();
        end
    endtask

    task automatic random_setting();
        int          w;
        int          h;
        int          cnt;
        logic [63:0] lo;
        logic [63:0] hi;
        case ($urandom_range(0, 15))
            0: begin w = 0; h = $urandom_range(0, 511); end
            1: begin w = $urandom_range(11, 40); h = 1; end
            2: begin w = 1; h = $urandom_range(11, 40); end
            3: begin w = $urandom_range(1, 10); h = 0; end
            default: begin w = $urandom_range(1, 10); h = $urandom_range(1, 10); end
        endcase
        cnt = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 16) : $urandom_range(0, 31);
        lo  = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : near_offsets();
        hi  = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : near_offsets();
        set_up_image(w, h, cnt, lo, hi);
    endtask

    initial begin
        int base;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: full 256x256 image, centre only; corner pixels
        send_request(OP_WRITE, 8'd0, 8'd0, 8'h00);
        send_request(OP_WRITE, 8'd255, 8'd255, 8'hFF);
        send_request(OP_WRITE, 8'd255, 8'd0, 8'hAA);
        send_request(OP_WRITE, 8'd0, 8'd255, 8'h55);
        send_request(OP_COMPUTE, 8'd0, 8'd0, 8'hFF);
        send_request(OP_COMPUTE, 8'd255, 8'd255, 8'h00);
        send_request(OP_COMPUTE, 8'd255, 8'd0, 8'h5A);
        send_request(OP_COMPUTE, 8'd0, 8'd255, 8'hA5);
        drain_results();

        // 3x3 image with the eight surrounding neighbours; edges clip, outside answers zero
        set_up_image(3, 3, 8, 64'h1110_1F01_0FF1_F0FF, 64'h0);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                send_request(OP_WRITE, 8'(x), 8'(y), 8'($urandom_range(0, 255)));
        send_request(OP_COMPUTE, 8'd0, 8'd0, 8'h00);
        send_request(OP_COMPUTE, 8'd2, 8'd2, 8'hFF);
        send_request(OP_COMPUTE, 8'd1, 8'd1, 8'h00);
        send_request(OP_COMPUTE, 8'd2, 8'd0, 8'hFF);
        send_request(OP_COMPUTE, 8'd3, 8'd1, 8'h00);
        send_request(OP_COMPUTE, 8'd0, 8'd7, 8'hFF);
        drain_results();

        // Empty image: every compute answers zero
        set_up_image(0, 5, 16, '1, '1);
        run_computes(10);
        drain_results();

        // Width saturates to the store, one row, count saturates, far offsets along x
        set_up_image(300, 1, 31, {8{8'h08}}, {8{8'h07}});
        load_window(224, 255, 0, 0);
        run_window_computes(16, 232, 255, 0, 0);
        drain_results();

        // Height saturates, one column, far offsets along y
        set_up_image(1, 511, 16, {8{8'h80}}, {8{8'h70}});
        load_window(0, 0, 224, 255);
        run_window_computes(16, 0, 0, 232, 255);
        drain_results();

        // Random image settings, each band loaded then dilated
        base = writes_sent + computes_sent;
        while (writes_sent + computes_sent - base < RANDOM_ITEMS) begin
            random_setting();
            load_band();
            run_computes($urandom_range(8, 40));
            drain_results();
        end

        $display("Covered %0d pixel writes and %0d dilation requests over %0d image settings,",
                 writes_sent, computes_sent, settings_used);
        $display("including empty and saturated sizes, saturated offset counts and stray indexes.");
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
src/gdil_pkg.sv
src/grayscale_dilation_top.sv
dv/dilation_checker.sv
dv/tb_grayscale_dilation_top.sv
